// ----- design/smeu_pkg.sv -----
// Package: opcodes, status codes, element and queue types for the stack execute unit.
package smeu_pkg;
    localparam int STACK_DEPTH = 16;
    localparam int LOCAL_COUNT = 16;
    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int LI_W = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;

    localparam logic [4:0] OP_PUSH = 5'd0;
    localparam logic [4:0] OP_POP = 5'd1;
    localparam logic [4:0] OP_LOAD = 5'd2;
    localparam logic [4:0] OP_STORE = 5'd3;
    localparam logic [4:0] OP_ADD = 5'd4;
    localparam logic [4:0] OP_SUB = 5'd5;
    localparam logic [4:0] OP_MUL = 5'd6;
    localparam logic [4:0] OP_DIV = 5'd7;
    localparam logic [4:0] OP_EQ = 5'd8;
    localparam logic [4:0] OP_NE = 5'd9;
    localparam logic [4:0] OP_LT = 5'd10;
    localparam logic [4:0] OP_LE = 5'd11;
    localparam logic [4:0] OP_GT = 5'd12;
    localparam logic [4:0] OP_GE = 5'd13;
    localparam logic [4:0] OP_BEQ = 5'd14;
    localparam logic [4:0] OP_BNE = 5'd15;
    localparam logic [4:0] OP_NEG = 5'd16;
    localparam logic [4:0] OP_NOT = 5'd17;
    localparam logic [4:0] OP_JIF = 5'd18;
    localparam logic [4:0] OP_JMP = 5'd19;
    localparam logic [4:0] OP_NOP = 5'd20;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_DIVZ = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_OVER = 3'd3;
    localparam logic [2:0] ST_HALT = 3'd4;

    typedef struct packed {
        logic [31:0] val;
        logic        is_bool;
    } t_elem;

    // decoded instruction carried from front to back
    typedef struct packed {
        logic [4:0]      act;
        logic [1:0]      need;
        logic            grows;
        logic [LI_W-1:0] li;
        t_elem           imm;
        logic [15:0]     tgt;
    } t_instr;

    typedef struct packed {
        logic [15:0] next_position;
        logic        jumped;
        logic [31:0] top_value;
        logic        top_is_bool;
        logic [2:0]  status;
    } t_result;
endpackage

// ----- design/smeu_if.sv -----
// Interfaces: valid/ready channels for instruction and result beats.
interface smeu_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  action;
    logic [3:0]  local_index;
    logic signed [31:0] immediate_value;
    logic        immediate_is_bool;
    logic [15:0] jump_target;
    modport source(output valid, action, local_index, immediate_value, immediate_is_bool,
                   jump_target, input ready);
    modport sink(input valid, action, local_index, immediate_value, immediate_is_bool,
                 jump_target, output ready);
endinterface

interface smeu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_position;
    logic        jumped;
    logic signed [31:0] top_value;
    logic        top_is_bool;
    logic [2:0]  status;
    modport source(output valid, next_position, jumped, top_value, top_is_bool, status,
                   input ready);
    modport sink(input valid, next_position, jumped, top_value, top_is_bool, status,
                 output ready);
endinterface

// ----- design/stack_machine_execute_unit_top.sv -----
// Top level: stack machine execute unit, front decode queue and back executor.
// The back takes a new instruction only after the result beat of the last one has been taken.
// The front queue holds two decoded beats, so input is taken while the back works.
// Reset: i_rst_n synchronous active low; clears position, stack count, halt and local valid flags.
module stack_machine_execute_unit_top
    import smeu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    smeu_in_if.sink   s_in,
    smeu_out_if.source m_out
);
    logic    w_q_valid, w_q_ready;
    t_instr  w_q_instr;
    t_result w_res;

    smeu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in),
        .o_valid(w_q_valid), .o_instr(w_q_instr), .i_ready(w_q_ready)
    );

    smeu_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .i_instr(w_q_instr), .o_ready(w_q_ready),
        .o_valid(m_out.valid), .o_res(w_res), .i_ready(m_out.ready)
    );

    assign m_out.next_position = w_res.next_position;
    assign m_out.jumped = w_res.jumped;
    assign m_out.top_value = w_res.top_value;
    assign m_out.top_is_bool = w_res.top_is_bool;
    assign m_out.status = w_res.status;

`ifndef SYNTH
    a_jump_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.jumped |-> m_out.status == ST_OK)
        else $error("jump with bad status");
    a_status_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> m_out.status <= ST_HALT)
        else $error("status out of range");
    a_halt_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.ready && m_out.status == ST_DIVZ
        |=> !m_out.valid || m_out.status == ST_HALT || $stable(m_out.next_position))
        else $error("position moved after halt");
`endif
endmodule

// ----- design/smeu_front.sv -----
// Front: accept instruction beats, decode operand needs, queue them for the back.
module smeu_front
    import smeu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    smeu_in_if.sink s_in,
    output logic   o_valid,
    output t_instr o_instr,
    input  logic   i_ready
);
    t_instr r_q [2];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;
    t_instr w_dec;
    logic   w_push, w_pop;

    always_comb begin
        w_dec.act = s_in.action;
        w_dec.li = LI_W'(32'(s_in.local_index) % LOCAL_COUNT);
        w_dec.imm.val = s_in.immediate_value;
        w_dec.imm.is_bool = s_in.immediate_is_bool;
        w_dec.tgt = s_in.jump_target;
        w_dec.grows = (s_in.action == OP_PUSH) || (s_in.action == OP_LOAD);
        if (s_in.action inside {OP_POP, OP_STORE, OP_NEG, OP_NOT, OP_JIF}) begin
            w_dec.need = 2'd1;
        end else if (s_in.action inside {[OP_ADD:OP_BNE]}) begin
            w_dec.need = 2'd2;
        end else begin
            w_dec.need = 2'd0;
        end
    end

    assign s_in.ready = (r_cnt != 2'd2);
    assign w_push = s_in.valid && s_in.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop = o_valid && i_ready;
    assign o_instr = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_dec;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ----- design/smeu_div.sv -----
// Divider: signed 32-bit restoring division, one quotient bit per cycle.
module smeu_div
    import smeu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_q
);
    logic [31:0] r_q, r_rem, r_mb;
    logic [5:0]  r_cnt;
    logic        r_neg, r_busy, r_done;
    logic [32:0] w_trial;
    logic [31:0] w_rem_sh;

    assign w_rem_sh = {r_rem[30:0], r_q[31]};
    assign w_trial = {1'b0, w_rem_sh} - {1'b0, r_mb};
    assign o_done = r_done;
    assign o_q = r_neg ? (32'd0 - r_q) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd32;
                r_q <= i_a[31] ? (32'd0 - i_a) : i_a;
                r_mb <= i_b[31] ? (32'd0 - i_b) : i_b;
                r_rem <= '0;
                r_neg <= i_a[31] ^ i_b[31];
            end else if (r_busy) begin
                if (!w_trial[32]) begin
                    r_rem <= w_trial[31:0];
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- design/smeu_back.sv -----
// Back: execute queued instructions against the operand stack and local store.
module smeu_back
    import smeu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_instr  i_instr,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} t_state;

    t_state      r_state;
    t_elem       r_stack [STACK_DEPTH];
    t_elem       r_loc [LOCAL_COUNT];
    logic [LOCAL_COUNT-1:0] r_loc_vld;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0] r_pc;
    logic        r_halt;
    t_result     r_res;
    t_instr      r_ins;
    logic [31:0] r_p, r_a, r_b;
    logic        r_div_go;

    t_elem       w_top, w_sec, w_loc, w_new_top, w_cur, w_rest, w_res_top, w_ex_el;
    logic [31:0] w_a, w_b, w_r, w_dq, w_ex;
    logic        w_rb, w_jmp, w_under, w_over, w_push_r, w_div_done, w_acc, w_div_start;
    logic signed [31:0] w_sa, w_sb;
    logic [CNT_W-1:0] w_cnt_n;
    logic [SP_W-1:0]  w_i1, w_i2, w_i3;
    logic [15:0] w_pc_inc, w_pc_n;

    smeu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_a(r_a), .i_b(r_b), .o_done(w_div_done), .o_q(w_dq)
    );

    assign w_i1 = SP_W'(r_cnt - CNT_W'(1));
    assign w_i2 = SP_W'(r_cnt - CNT_W'(2));
    assign w_top = r_stack[w_i1];
    assign w_sec = r_stack[w_i2];
    assign w_loc = r_loc_vld[i_instr.li] ? r_loc[i_instr.li] : '0;
    assign w_a = (i_instr.need == 2'd2) ? w_sec.val : w_top.val;
    assign w_b = w_top.val;
    assign w_sa = w_a;
    assign w_sb = w_b;
    assign w_under = r_cnt < CNT_W'(i_instr.need);
    assign w_over = i_instr.grows && (r_cnt >= CNT_W'(STACK_DEPTH));
    assign w_push_r = i_instr.act inside {[OP_ADD:OP_NOT]};
    assign w_cnt_n = r_cnt - CNT_W'(i_instr.need);
    assign w_i3 = SP_W'(w_cnt_n - CNT_W'(1));
    assign w_cur = (r_cnt != '0) ? w_top : '0;
    assign w_rest = (w_cnt_n != '0) ? r_stack[w_i3] : '0;
    assign w_pc_inc = r_pc + 16'd1;
    assign w_pc_n = w_jmp ? i_instr.tgt : w_pc_inc;
    assign o_ready = (r_state == S_IDLE) && !r_div_go;
    assign w_acc = i_valid && o_ready;
    assign w_div_start = w_acc && !r_halt && !w_under && !w_over
                         && (i_instr.act == OP_DIV) && (w_b != 32'd0);
    assign o_valid = (r_state == S_OUT);
    assign o_res = r_res;
    assign w_ex = (r_ins.act == OP_MUL) ? r_p : w_dq;
    assign w_ex_el.val = w_ex;
    assign w_ex_el.is_bool = 1'b0;

    always_comb begin
        w_rb = 1'b1;
        w_r = '0;
        w_jmp = 1'b0;
        case (i_instr.act)
            OP_ADD: begin w_r = w_a + w_b; w_rb = 1'b0; end
            OP_SUB: begin w_r = w_a - w_b; w_rb = 1'b0; end
            OP_MUL: begin w_r = r_p; w_rb = 1'b0; end
            OP_EQ: w_r = 32'(w_a == w_b);
            OP_NE: w_r = 32'(w_a != w_b);
            OP_LT: w_r = 32'(w_sa < w_sb);
            OP_LE: w_r = 32'(w_sa <= w_sb);
            OP_GT: w_r = 32'(w_sa > w_sb);
            OP_GE: w_r = 32'(w_sa >= w_sb);
            OP_BEQ: w_r = 32'((w_a != 0) == (w_b != 0));
            OP_BNE: w_r = 32'((w_a != 0) != (w_b != 0));
            OP_NEG: begin w_r = 32'd0 - w_a; w_rb = 1'b0; end
            OP_NOT: w_r = 32'(w_a == 0);
            OP_JIF: w_jmp = (w_a == 0);
            OP_JMP: w_jmp = 1'b1;
            default: w_rb = 1'b0;
        endcase
        w_new_top.val = w_r;
        w_new_top.is_bool = w_rb;
    end

    always_comb begin
        if (i_instr.act == OP_PUSH) begin
            w_res_top = i_instr.imm;
        end else if (i_instr.act == OP_LOAD) begin
            w_res_top = w_loc;
        end else if (w_push_r) begin
            w_res_top = w_new_top;
        end else begin
            w_res_top = w_rest;
        end
    end

    // product registered ahead of use; mul waits in S_DIV for it
    always_ff @(posedge i_clk) begin
        r_p <= w_a * w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_pc <= '0;
            r_halt <= 1'b0;
            r_loc_vld <= '0;
            r_div_go <= 1'b0;
            r_ins <= '0;
        end else begin
            r_div_go <= w_div_start;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_ins <= i_instr;
                        r_a <= w_a;
                        r_b <= w_b;
                        if (r_halt) begin
                            r_res.status <= ST_HALT;
                            r_res.jumped <= 1'b0;
                            r_res.next_position <= r_pc;
                            r_res.top_value <= w_cur.val;
                            r_res.top_is_bool <= w_cur.is_bool;
                            r_state <= S_OUT;
                        end else if (w_under || w_over) begin
                            r_res.status <= w_under ? ST_UNDER : ST_OVER;
                            r_res.jumped <= 1'b0;
                            r_pc <= w_pc_inc;
                            r_res.next_position <= w_pc_inc;
                            r_res.top_value <= w_cur.val;
                            r_res.top_is_bool <= w_cur.is_bool;
                            r_state <= S_OUT;
                        end else if (i_instr.act == OP_DIV && w_b == 32'd0) begin
                            r_res.status <= ST_DIVZ;
                            r_res.jumped <= 1'b0;
                            r_halt <= 1'b1;
                            r_res.next_position <= r_pc;
                            r_res.top_value <= w_top.val;
                            r_res.top_is_bool <= w_top.is_bool;
                            r_state <= S_OUT;
                        end else if (i_instr.act == OP_DIV || i_instr.act == OP_MUL) begin
                            r_state <= S_DIV;
                        end else begin
                            r_res.status <= ST_OK;
                            r_res.jumped <= w_jmp;
                            r_pc <= w_pc_n;
                            r_res.next_position <= w_pc_n;
                            r_res.top_value <= w_res_top.val;
                            r_res.top_is_bool <= w_res_top.is_bool;
                            r_state <= S_OUT;
                            if (i_instr.act == OP_PUSH) begin
                                r_stack[SP_W'(r_cnt)] <= i_instr.imm;
                                r_cnt <= r_cnt + CNT_W'(1);
                            end else if (i_instr.act == OP_LOAD) begin
                                r_stack[SP_W'(r_cnt)] <= w_loc;
                                r_cnt <= r_cnt + CNT_W'(1);
                            end else if (w_push_r) begin
                                r_stack[SP_W'(w_cnt_n)] <= w_new_top;
                                r_cnt <= w_cnt_n + CNT_W'(1);
                            end else begin
                                if (i_instr.act == OP_STORE) begin
                                    r_loc[i_instr.li] <= w_top;
                                    r_loc_vld[i_instr.li] <= 1'b1;
                                end
                                r_cnt <= w_cnt_n;
                            end
                        end
                    end
                end
                S_DIV: begin
                    // finish mul as soon as S_DIV is entered, div when the divider reports done
                    if ((r_ins.act == OP_MUL) || w_div_done) begin
                        r_stack[w_i2] <= w_ex_el;
                        r_cnt <= r_cnt - CNT_W'(1);
                        r_res.top_value <= w_ex;
                        r_res.top_is_bool <= 1'b0;
                        r_res.status <= ST_OK;
                        r_res.jumped <= 1'b0;
                        r_pc <= w_pc_inc;
                        r_res.next_position <= w_pc_inc;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- bench/tb_scoreboard.sv -----
// Scoreboard: predicts execute-unit results from accepted instruction beats and checks them.
class smeu_scoreboard;
    logic [15:0] pos;
    logic [31:0] stk_val [smeu_pkg::STACK_DEPTH];
    logic        stk_tag [smeu_pkg::STACK_DEPTH];
    logic [31:0] loc_val [smeu_pkg::LOCAL_COUNT];
    logic        loc_tag [smeu_pkg::LOCAL_COUNT];
    int          depth;
    bit          halted;
    smeu_pkg::t_result pending[$];
    int          errors;

    function new();
        pos = 0;
        depth = 0;
        halted = 0;
        errors = 0;
        for (int i = 0; i < smeu_pkg::LOCAL_COUNT; i++) begin
            loc_val[i] = 0;
            loc_tag[i] = 0;
        end
        for (int i = 0; i < smeu_pkg::STACK_DEPTH; i++) begin
            stk_val[i] = 0;
            stk_tag[i] = 0;
        end
    endfunction

    function void push_elem(logic [31:0] v, logic t);
        stk_val[depth] = v;
        stk_tag[depth] = t;
        depth++;
    endfunction

    function void note_instr(logic [4:0] act, logic [3:0] li_in, logic [31:0] imm,
                             logic immb, logic [15:0] tgt);
        smeu_pkg::t_result r;
        int need;
        bit grows;
        logic [31:0] a, b, q, ma, mb;
        logic jmp;
        logic [2:0] st;
        int li;
        logic [31:0] rv;
        logic rb;
        li = li_in % smeu_pkg::LOCAL_COUNT;
        need = 0;
        jmp = 0;
        st = smeu_pkg::ST_OK;
        a = 0;
        b = 0;
        rv = 0;
        rb = 0;
        if (halted) begin
            st = smeu_pkg::ST_HALT;
        end else begin
            if (act == smeu_pkg::OP_POP || act == smeu_pkg::OP_STORE ||
                (act >= smeu_pkg::OP_NEG && act <= smeu_pkg::OP_JIF))
                need = 1;
            else if (act >= smeu_pkg::OP_ADD && act <= smeu_pkg::OP_BNE)
                need = 2;
            grows = (act == smeu_pkg::OP_PUSH || act == smeu_pkg::OP_LOAD);
            if (depth < need) begin
                st = smeu_pkg::ST_UNDER;
            end else if (grows && depth >= smeu_pkg::STACK_DEPTH) begin
                st = smeu_pkg::ST_OVER;
            end else if (act == smeu_pkg::OP_DIV && stk_val[depth-1] == 0) begin
                st = smeu_pkg::ST_DIVZ;
                halted = 1;
            end else begin
                if (need == 2) begin
                    b = stk_val[depth-1];
                    a = stk_val[depth-2];
                end else if (need == 1) begin
                    a = stk_val[depth-1];
                end
                depth -= need;
                case (act)
                    smeu_pkg::OP_PUSH: push_elem(imm, immb);
                    smeu_pkg::OP_LOAD: push_elem(loc_val[li], loc_tag[li]);
                    smeu_pkg::OP_STORE: begin
                        loc_val[li] = stk_val[depth];
                        loc_tag[li] = stk_tag[depth];
                    end
                    smeu_pkg::OP_ADD: rv = a + b;
                    smeu_pkg::OP_SUB: rv = a - b;
                    smeu_pkg::OP_MUL: rv = a * b;
                    smeu_pkg::OP_DIV: begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        rv = (a[31] ^ b[31]) ? -q : q;
                    end
                    smeu_pkg::OP_EQ: begin rv = 32'(a == b); rb = 1; end
                    smeu_pkg::OP_NE: begin rv = 32'(a != b); rb = 1; end
                    smeu_pkg::OP_LT: begin rv = 32'($signed(a) < $signed(b)); rb = 1; end
                    smeu_pkg::OP_LE: begin rv = 32'($signed(a) <= $signed(b)); rb = 1; end
                    smeu_pkg::OP_GT: begin rv = 32'($signed(a) > $signed(b)); rb = 1; end
                    smeu_pkg::OP_GE: begin rv = 32'($signed(a) >= $signed(b)); rb = 1; end
                    smeu_pkg::OP_BEQ: begin rv = 32'((a != 0) == (b != 0)); rb = 1; end
                    smeu_pkg::OP_BNE: begin rv = 32'((a != 0) != (b != 0)); rb = 1; end
                    smeu_pkg::OP_NEG: rv = -a;
                    smeu_pkg::OP_NOT: begin rv = 32'(a == 0); rb = 1; end
                    smeu_pkg::OP_JIF: jmp = (a == 0);
                    smeu_pkg::OP_JMP: jmp = 1;
                    default: ;
                endcase
                if (act >= smeu_pkg::OP_ADD && act <= smeu_pkg::OP_NOT)
                    push_elem(rv, rb);
            end
            if (st != smeu_pkg::ST_DIVZ)
                pos = jmp ? tgt : pos + 16'd1;
        end
        r.next_position = pos;
        r.jumped = jmp;
        r.top_value = depth ? stk_val[depth-1] : 32'd0;
        r.top_is_bool = depth ? stk_tag[depth-1] : 1'b0;
        r.status = st;
        pending.insert(pending.size(), r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task check_result(smeu_pkg::t_result got);
        smeu_pkg::t_result w;
        if (pending.size() == 0) begin
            report("unexpected beat", 32'd0, 32'd0);
        end else begin
            w = pending.pop_front();
            if (got.next_position !== w.next_position)
                report("next_position", 32'(got.next_position), 32'(w.next_position));
            if (got.jumped !== w.jumped) report("jumped", 32'(got.jumped), 32'(w.jumped));
            if (got.top_value !== w.top_value) report("top_value", got.top_value, w.top_value);
            if (got.top_is_bool !== w.top_is_bool)
                report("top_is_bool", 32'(got.top_is_bool), 32'(w.top_is_bool));
            if (got.status !== w.status) report("status", 32'(got.status), 32'(w.status));
        end
    endtask
endclass

// ----- bench/tb_top.sv -----
// Testbench top: drives instruction beats, stalls results at random and checks each one.
module tb_top;
    import smeu_pkg::*;

    localparam logic [4:0] OP_SPARE = 5'd31;

    logic i_clk;
    logic i_rst_n;
    smeu_in_if  s_in();
    smeu_out_if m_out();
    smeu_scoreboard sb;
    bit stim_done;
    int n_sent;

    stack_machine_execute_unit_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in.sink), .m_out(m_out.source)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(logic [4:0] act, logic [3:0] li, logic [31:0] imm, logic ib,
                        logic [15:0] tgt);
        s_in.valid <= 1;
        s_in.action <= act;
        s_in.local_index <= li;
        s_in.immediate_value <= imm;
        s_in.immediate_is_bool <= ib;
        s_in.jump_target <= tgt;
        do @(posedge i_clk); while (!s_in.ready);
        sb.note_instr(act, li, imm, ib, tgt);
        n_sent++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_in.valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic rand_item(bit gaps);
        logic [4:0] act;
        logic [31:0] imm;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) act = OP_PUSH;
        else if (r < 38) act = OP_LOAD;
        else if (r < 44) act = OP_STORE;
        else act = 5'($urandom_range(0, 31));
        imm = rand_val();
        if (act == OP_DIV && $urandom_range(0, 150) != 0 && sb.depth > 0
            && sb.stk_val[sb.depth-1] == 0)
            act = OP_SUB;
        send(act, 4'($urandom), imm, 1'($urandom), 16'($urandom));
        if (gaps) idle_gap(gap_len());
    endtask

    task automatic do_reset();
        i_rst_n <= 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        s_in.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        stim_done = 0;
        n_sent = 0;
        i_rst_n = 0;
        s_in.valid = 0;
        s_in.action = 0;
        s_in.local_index = 0;
        s_in.immediate_value = 0;
        s_in.immediate_is_bool = 0;
        s_in.jump_target = 0;
        @(posedge i_clk);
        do_reset();
        send(OP_POP, 0, 0, 0, 0);
        send(OP_ADD, 0, 0, 0, 0);
        send(OP_LOAD, 15, 0, 0, 0);
        send(OP_PUSH, 0, 32'h8000_0000, 0, 0);
        send(OP_PUSH, 0, 32'hffff_ffff, 0, 0);
        send(OP_DIV, 0, 0, 0, 0);
        send(OP_PUSH, 0, 32'h7fff_ffff, 1, 0);
        send(OP_STORE, 15, 0, 0, 0);
        send(OP_PUSH, 0, 5, 1, 0);
        send(OP_NOT, 0, 0, 0, 0);
        send(OP_JIF, 0, 0, 0, 16'hffff);
        send(OP_JMP, 0, 0, 0, 16'h0000);
        send(OP_SPARE, 0, 0, 0, 0);
        send(OP_NOP, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++) send(OP_PUSH, 4'(i), $urandom, i[0], 0);
        send(OP_LT, 0, 0, 0, 0);
        send(OP_NEG, 0, 0, 0, 0);
        send(OP_BEQ, 0, 0, 0, 0);
        wait_drain();
        for (int k = 0; k < 1250; k++) begin
            rand_item(k % 200 > 30);
            if (k == 600) wait_drain();
        end
        send(OP_PUSH, 0, 0, 0, 0);
        send(OP_DIV, 0, 0, 0, 0);
        for (int k = 0; k < 5; k++) rand_item(1);
        s_in.valid <= 0;
        stim_done = 1;
    end

    initial begin
        int stall;
        smeu_pkg::t_result got;
        m_out.ready = 0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_out.valid && m_out.ready) begin
                got.next_position = m_out.next_position;
                got.jumped = m_out.jumped;
                got.top_value = m_out.top_value;
                got.top_is_bool = m_out.top_is_bool;
                got.status = m_out.status;
                sb.check_result(got);
            end
            if (stall > 0) begin
                stall--;
                m_out.ready <= 0;
            end else begin
                m_out.ready <= 1;
                if ((n_sent / 300) % 2 == 1) stall = gap_len();
            end
        end
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
